### rtl/glc_pkg.sv
`timescale 1ns / 1ps

package glc_pkg;

  localparam int LINE_LENGTH_DEF = 128;

  localparam int POS_W  = 7;
  localparam int LNUM_W = 16;

  typedef enum logic [2:0] {
    EV_CHAR     = 3'd0,
    EV_LINE     = 3'd1,
    EV_QUERY    = 3'd2,
    EV_ACK      = 3'd3,
    EV_RESET    = 3'd4,
    EV_OVERFLOW = 3'd5,
    EV_END      = 3'd6
  } ev_kind_t;

  typedef enum logic [2:0] {
    Q_STATUS = 3'd0,
    Q_INFO   = 3'd1,
    Q_SETS   = 3'd2,
    Q_GMODE  = 3'd3,
    Q_START  = 3'd4,
    Q_UNLOCK = 3'd5,
    Q_PARAMS = 3'd6,
    Q_HOME   = 3'd7
  } query_t;

  localparam logic [7:0] CH_CAN    = 8'h18;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_TILDE  = 8'h7E;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_QMARK  = 8'h3F;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_UA     = 8'h41;
  localparam logic [7:0] CH_UG     = 8'h47;
  localparam logic [7:0] CH_UH     = 8'h48;
  localparam logic [7:0] CH_UI     = 8'h49;
  localparam logic [7:0] CH_UN     = 8'h4E;
  localparam logic [7:0] CH_UX     = 8'h58;
  localparam logic [7:0] CH_LA     = 8'h61;
  localparam logic [7:0] CH_LZ     = 8'h7A;

  localparam logic [2:0] REG_FILE_MODE = 3'd0;

  typedef struct packed {
    ev_kind_t             kind;
    logic [7:0]           ch;
    logic [POS_W-1:0]     pos;
    logic [POS_W-1:0]     len;
    query_t               query;
    logic [LNUM_W-1:0]    line_no;
  } glc_event_t;

endpackage

### rtl/gcode_line_cleaner_core.sv
`timescale 1ns / 1ps
// Latency: a result beat is presented the cycle after its input beat is accepted.
// Throughput: one byte per cycle unless a result beat stalls; line state updates per beat.
// A result beat waiting in the output register does not block input while out_tready is high.
// Reset (rst_n low, synchronous): empty line, no comment, line counter 1,
// serial mode, output register empty.

module gcode_line_cleaner_core #(
  parameter int LINE_LENGTH = glc_pkg::LINE_LENGTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // data_byte
  input  logic        in_tlast,   // end_of_stream
  output logic        out_tvalid,
  input  logic        out_tready,
  // kept_char[7:0], char_position[14:8], line_length[21:15], query_code[24:22],
  // line_number[40:25], zero[47:41]
  output logic [47:0] out_tdata,
  output logic [2:0]  out_tuser,  // event_kind
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int FW = $clog2(LINE_LENGTH);

  logic                         file_mode_r;
  logic [FW-1:0]                fill_r, fill_nxt;
  logic                         paren_r, paren_nxt;
  logic                         semi_r, semi_nxt;
  logic [7:0]                   first_r, first_nxt;
  logic [7:0]                   second_r, second_nxt;
  logic [glc_pkg::LNUM_W-1:0]   lines_r, lines_nxt;
  logic                         out_valid_r, out_valid_nxt;
  glc_pkg::glc_event_t          out_ev_r, ev;
  logic                         emit;
  logic                         in_acc;
  logic                         cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr == glc_pkg::REG_FILE_MODE) ? {31'd0, file_mode_r} : 32'd0;

  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;

  glc_decode #(
    .LINE_LENGTH (LINE_LENGTH),
    .FW          (FW)
  ) u_decode (
    .data_byte  (in_tdata),
    .eos        (in_tlast),
    .file_mode  (file_mode_r),
    .fill       (fill_r),
    .paren      (paren_r),
    .semi       (semi_r),
    .first      (first_r),
    .second     (second_r),
    .lines      (lines_r),
    .fill_nxt   (fill_nxt),
    .paren_nxt  (paren_nxt),
    .semi_nxt   (semi_nxt),
    .first_nxt  (first_nxt),
    .second_nxt (second_nxt),
    .lines_nxt  (lines_nxt),
    .emit       (emit),
    .ev         (ev)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_acc) begin
      out_valid_nxt = emit;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      file_mode_r <= 1'b0;
    end else if (cfg_wr && cfg_paddr[2] == 1'b0) begin
      file_mode_r <= cfg_pwdata[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      paren_r     <= 1'b0;
      semi_r      <= 1'b0;
      first_r     <= '0;
      second_r    <= '0;
      lines_r     <= glc_pkg::LNUM_W'(1);
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_acc) begin
        fill_r   <= fill_nxt;
        paren_r  <= paren_nxt;
        semi_r   <= semi_nxt;
        first_r  <= first_nxt;
        second_r <= second_nxt;
        lines_r  <= lines_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && emit) begin
      out_ev_r <= ev;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_ev_r.kind;
  assign out_tdata  = {7'd0, out_ev_r.line_no, out_ev_r.query, out_ev_r.len,
                       out_ev_r.pos, out_ev_r.ch};

  a_full_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_tready |-> !in_tready)
    else $error("input taken while result beat stalled");

  a_eos_restarts_count: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_tlast && file_mode_r |=> lines_r == glc_pkg::LNUM_W'(1) && fill_r == '0)
    else $error("end of stream did not restart line state");

  a_char_advances_fill: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && emit && ev.kind == glc_pkg::EV_CHAR |=> fill_r != '0)
    else $error("kept character did not advance fill");

  a_fill_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FW'(LINE_LENGTH - 1))
    else $error("fill count beyond line length");

  a_char_fields_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_ev_r.kind == glc_pkg::EV_CHAR |->
      out_ev_r.len == '0 && out_ev_r.line_no == '0)
    else $error("character beat carries line fields");

endmodule

### rtl/glc_decode.sv
`timescale 1ns / 1ps

module glc_decode #(
  parameter int LINE_LENGTH = glc_pkg::LINE_LENGTH_DEF,
  parameter int FW          = $clog2(LINE_LENGTH)
) (
  input  logic [7:0]                   data_byte,
  input  logic                         eos,
  input  logic                         file_mode,
  input  logic [FW-1:0]                fill,
  input  logic                         paren,
  input  logic                         semi,
  input  logic [7:0]                   first,
  input  logic [7:0]                   second,
  input  logic [glc_pkg::LNUM_W-1:0]   lines,
  output logic [FW-1:0]                fill_nxt,
  output logic                         paren_nxt,
  output logic                         semi_nxt,
  output logic [7:0]                   first_nxt,
  output logic [7:0]                   second_nxt,
  output logic [glc_pkg::LNUM_W-1:0]   lines_nxt,
  output logic                         emit,
  output glc_pkg::glc_event_t          ev
);

  localparam int MW = (FW > glc_pkg::POS_W) ? FW : glc_pkg::POS_W;
  localparam logic [FW-1:0] FILL_LAST = FW'(LINE_LENGTH - 1);

  logic [MW-1:0]           fill_ext;
  logic [glc_pkg::POS_W-1:0] fill7;
  logic                    q_hit;
  glc_pkg::query_t         q_code;
  logic [7:0]              up;

  assign fill_ext = MW'(fill);
  assign fill7    = fill_ext[glc_pkg::POS_W-1:0];

  always_comb begin
    q_hit  = 1'b0;
    q_code = glc_pkg::Q_STATUS;
    if (fill == FW'(1) && first == glc_pkg::CH_QMARK) begin
      q_hit = 1'b1;
    end else if (fill == FW'(2) && first == glc_pkg::CH_DOLLAR) begin
      q_hit = 1'b1;
      case (second)
        glc_pkg::CH_UI:     q_code = glc_pkg::Q_INFO;
        glc_pkg::CH_DOLLAR: q_code = glc_pkg::Q_SETS;
        glc_pkg::CH_UG:     q_code = glc_pkg::Q_GMODE;
        glc_pkg::CH_UN:     q_code = glc_pkg::Q_START;
        glc_pkg::CH_UX:     q_code = glc_pkg::Q_UNLOCK;
        glc_pkg::CH_HASH:   q_code = glc_pkg::Q_PARAMS;
        glc_pkg::CH_UH:     q_code = glc_pkg::Q_HOME;
        default:            q_hit  = 1'b0;
      endcase
    end
  end

  always_comb begin
    up = data_byte;
    if (data_byte inside {[glc_pkg::CH_LA:glc_pkg::CH_LZ]}) begin
      up = data_byte - (glc_pkg::CH_LA - glc_pkg::CH_UA);
    end
  end

  always_comb begin
    fill_nxt   = fill;
    paren_nxt  = paren;
    semi_nxt   = semi;
    first_nxt  = first;
    second_nxt = second;
    lines_nxt  = lines;
    emit       = 1'b0;
    ev         = '0;
    if (eos) begin
      if (file_mode) begin
        emit       = 1'b1;
        ev.kind    = glc_pkg::EV_END;
        ev.len     = fill7;
        ev.line_no = lines;
        fill_nxt   = '0;
        paren_nxt  = 1'b0;
        semi_nxt   = 1'b0;
        lines_nxt  = glc_pkg::LNUM_W'(1);
      end
    end else if (!file_mode &&
                 (data_byte == glc_pkg::CH_BANG || data_byte == glc_pkg::CH_TILDE)) begin
      emit    = 1'b1;
      ev.kind = glc_pkg::EV_ACK;
    end else if (!file_mode && data_byte == glc_pkg::CH_CAN) begin
      emit      = 1'b1;
      ev.kind   = glc_pkg::EV_RESET;
      fill_nxt  = '0;
      paren_nxt = 1'b0;
      semi_nxt  = 1'b0;
    end else if (data_byte == glc_pkg::CH_LF || data_byte == glc_pkg::CH_CR) begin
      if (fill != '0) begin
        emit   = 1'b1;
        ev.len = fill7;
        if (!file_mode && q_hit) begin
          ev.kind  = glc_pkg::EV_QUERY;
          ev.query = q_code;
        end else begin
          ev.kind    = glc_pkg::EV_LINE;
          ev.line_no = file_mode ? lines : '0;
        end
      end
      fill_nxt  = '0;
      paren_nxt = 1'b0;
      semi_nxt  = 1'b0;
      if (file_mode) begin
        lines_nxt = lines + glc_pkg::LNUM_W'(1);
      end
    end else if (paren || semi) begin
      if (data_byte == glc_pkg::CH_RPAREN) begin
        paren_nxt = 1'b0;
      end
    end else if (data_byte <= glc_pkg::CH_SPACE || data_byte == glc_pkg::CH_SLASH) begin
      emit = 1'b0;
    end else if (data_byte == glc_pkg::CH_LPAREN) begin
      paren_nxt = 1'b1;
    end else if (data_byte == glc_pkg::CH_SEMI) begin
      semi_nxt = 1'b1;
    end else if (fill >= FILL_LAST) begin
      emit      = 1'b1;
      ev.kind   = glc_pkg::EV_OVERFLOW;
      fill_nxt  = '0;
      paren_nxt = 1'b0;
      semi_nxt  = 1'b0;
    end else begin
      emit     = 1'b1;
      ev.kind  = glc_pkg::EV_CHAR;
      ev.ch    = up;
      ev.pos   = fill7;
      fill_nxt = fill + FW'(1);
      if (fill == '0) begin
        first_nxt = up;
      end else if (fill == FW'(1)) begin
        second_nxt = up;
      end
    end
  end

endmodule

### test/gcode_line_cleaner_core_test.sv
`timescale 1ns / 1ps

module gcode_line_cleaner_core_test;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;   // data_byte
  logic        in_tlast = 1'b0; // end_of_stream
  logic        out_tvalid;
  logic        out_tready = 1'b1;
  // kept_char[7:0], char_position[14:8], line_length[21:15], query_code[24:22],
  // line_number[40:25], zero[47:41]
  logic [47:0] out_tdata;
  logic [2:0]  out_tuser;       // event_kind
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  gcode_line_cleaner_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always #4 clk = ~clk;

  // line state mirrored from the block
  bit          mode_file = 1'b0;
  int          line_fill = 0;
  bit          in_paren = 1'b0;
  bit          in_semi = 1'b0;
  logic [7:0]  first_ch = '0;
  logic [7:0]  second_ch = '0;
  logic [15:0] line_count = 16'd1;

  glc_pkg::glc_event_t line_events[$];
  int          mismatches = 0;
  int          sent_items = 0;
  int          burst_left = 0;
  bit          sender_steady = 1'b0;
  int          stall_request = 0;
  int          hold_left = 0;
  int          rx_run = 0;
  int          rx_style = 0;

  string query_lines[$] = '{"?", "$I", "$$", "$G", "$N", "$X", "$#", "$H",
                            "$i", "$x", "$g", "$h", "$A", "$", "??", "$$$"};
  string number_chars = "0123456789.-";

  function automatic void clear_line_state();
    line_fill = 0;
    in_paren  = 1'b0;
    in_semi   = 1'b0;
  endfunction

  function automatic void clean_byte(logic [7:0] b, logic eos);
    glc_pkg::glc_event_t ev;
    logic [7:0]      c;
    glc_pkg::query_t qk;
    bit              is_query;
    ev = '0;
    c = b;
    qk = glc_pkg::Q_STATUS;
    is_query = 1'b0;
    if (eos) begin
      if (mode_file) begin
        ev.kind = glc_pkg::EV_END;
        ev.len = 7'(line_fill);
        ev.line_no = line_count;
        line_events.push_back(ev);
        clear_line_state();
        line_count = 16'd1;
      end
      return;
    end
    if (!mode_file && (c == glc_pkg::CH_BANG || c == glc_pkg::CH_TILDE)) begin
      ev.kind = glc_pkg::EV_ACK;
      line_events.push_back(ev);
      return;
    end
    if (!mode_file && c == glc_pkg::CH_CAN) begin
      clear_line_state();
      ev.kind = glc_pkg::EV_RESET;
      line_events.push_back(ev);
      return;
    end
    if (c == glc_pkg::CH_LF || c == glc_pkg::CH_CR) begin
      if (line_fill > 0) begin
        if (!mode_file && line_fill == 1 && first_ch == glc_pkg::CH_QMARK) begin
          is_query = 1'b1;
        end else if (!mode_file && line_fill == 2 && first_ch == glc_pkg::CH_DOLLAR) begin
          is_query = 1'b1;
          case (second_ch)
            glc_pkg::CH_UI:     qk = glc_pkg::Q_INFO;
            glc_pkg::CH_DOLLAR: qk = glc_pkg::Q_SETS;
            glc_pkg::CH_UG:     qk = glc_pkg::Q_GMODE;
            glc_pkg::CH_UN:     qk = glc_pkg::Q_START;
            glc_pkg::CH_UX:     qk = glc_pkg::Q_UNLOCK;
            glc_pkg::CH_HASH:   qk = glc_pkg::Q_PARAMS;
            glc_pkg::CH_UH:     qk = glc_pkg::Q_HOME;
            default:            is_query = 1'b0;
          endcase
        end
        ev.len = 7'(line_fill);
        if (is_query) begin
          ev.kind = glc_pkg::EV_QUERY;
          ev.query = qk;
        end else begin
          ev.kind = glc_pkg::EV_LINE;
          if (mode_file) ev.line_no = line_count;
        end
        line_events.push_back(ev);
      end
      clear_line_state();
      if (mode_file) line_count = line_count + 16'd1;
      return;
    end
    if (in_paren || in_semi) begin
      if (c == glc_pkg::CH_RPAREN) in_paren = 1'b0;
      return;
    end
    if (c <= glc_pkg::CH_SPACE || c == glc_pkg::CH_SLASH) return;
    if (c == glc_pkg::CH_LPAREN) begin
      in_paren = 1'b1;
      return;
    end
    if (c == glc_pkg::CH_SEMI) begin
      in_semi = 1'b1;
      return;
    end
    if (line_fill >= glc_pkg::LINE_LENGTH_DEF - 1) begin
      clear_line_state();
      ev.kind = glc_pkg::EV_OVERFLOW;
      line_events.push_back(ev);
      return;
    end
    if (c >= glc_pkg::CH_LA && c <= glc_pkg::CH_LZ) c = c - (glc_pkg::CH_LA - glc_pkg::CH_UA);
    if (line_fill == 0) first_ch = c;
    else if (line_fill == 1) second_ch = c;
    ev.kind = glc_pkg::EV_CHAR;
    ev.ch = c;
    ev.pos = 7'(line_fill);
    line_events.push_back(ev);
    line_fill++;
  endfunction

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    glc_pkg::glc_event_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (line_events.size() == 0) begin
        $error("result beat with none pending: kind %0d data %0h", out_tuser, out_tdata);
        mismatches++;
      end else begin
        want = line_events.pop_front();
        check_field("event_kind", 16'(want.kind), 16'(out_tuser));
        check_field("kept_char", 16'(want.ch), 16'(out_tdata[7:0]));
        check_field("char_position", 16'(want.pos), 16'(out_tdata[14:8]));
        check_field("line_length", 16'(want.len), 16'(out_tdata[21:15]));
        check_field("query_code", 16'(want.query), 16'(out_tdata[24:22]));
        check_field("line_number", want.line_no, out_tdata[40:25]);
        check_field("zero", '0, 16'(out_tdata[47:41]));
      end
    end
  end

  // result side: long hold on request, otherwise a pattern of stall runs
  always @(posedge clk) begin
    if (stall_request != 0) begin
      hold_left = stall_request;
      stall_request = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      if (rx_run == 0) begin
        rx_style = $urandom_range(0, 2);
        rx_run = $urandom_range(4, 40);
      end
      rx_run--;
      case (rx_style)
        0:       out_tready <= 1'b1;
        1:       out_tready <= 1'($urandom_range(0, 1));
        default: out_tready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  task automatic send_beat(input logic [7:0] b, input logic eos);
    int gap;
    if (!sender_steady && burst_left == 0) begin
      gap = $urandom_range(1, 6);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    if (burst_left > 0) burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= eos;
    do @(posedge clk); while (!in_tready);
    clean_byte(b, eos);
    sent_items++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_beat(s[i], 1'b0);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (line_events.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_mode(input bit v);
    drain();
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= glc_pkg::REG_FILE_MODE;
    cfg_pwdata  <= {31'b0, v};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    mode_file = v;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    check_field("file_mode", {15'b0, v}, cfg_prdata[15:0]);
    check_field("file_mode upper", '0, cfg_prdata[31:16]);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic test_serial_line();
    send_text("g1 x-2.5(feed)/y7;tail\n");
    send_text("?\r$x\n$a\n\r");
    send_beat(8'h00, 1'b0);
    send_beat(8'hFF, 1'b0);
    send_beat(8'h80, 1'b0);
    send_beat(8'h7F, 1'b0);
    send_beat(glc_pkg::CH_LF, 1'b0);
    send_beat(8'hA5, 1'b1);
  endtask

  task automatic test_realtime();
    send_text("m3(a!~");
    send_beat(glc_pkg::CH_CAN, 1'b0);
    send_text("s)~!;z!\n");
  endtask

  task automatic test_file_mode();
    write_mode(1'b1);
    send_text("!~");
    send_beat(glc_pkg::CH_CAN, 1'b0);
    send_text("a)\n?\n\n$h\r");
    send_text("(x\nm3");
    send_beat(8'h5A, 1'b1);
    send_beat(8'hFF, 1'b1);
    write_mode(1'b0);
  endtask

  task automatic test_overflow();
    for (int i = 0; i < 127; i++) send_beat(glc_pkg::CH_UA + 8'(i % 26), 1'b0);
    send_beat(glc_pkg::CH_LF, 1'b0);
    for (int i = 0; i < 128; i++) send_beat(glc_pkg::CH_LA + 8'(i % 26), 1'b0);
    send_text("b\n");
  endtask

  task automatic test_line_count();
    write_mode(1'b1);
    sender_steady = 1'b1;
    for (int i = 0; i < 100; i++) send_beat(glc_pkg::CH_LF, 1'b0);
    send_text("a\nb\n");
    send_beat(8'h00, 1'b1);
    sender_steady = 1'b0;
    write_mode(1'b0);
  endtask

  task automatic test_backpressure();
    stall_request = 300;
    for (int i = 0; i < 80; i++) send_beat(glc_pkg::CH_UA + 8'($urandom_range(0, 25)), 1'b0);
    send_beat(glc_pkg::CH_LF, 1'b0);
  endtask

  task automatic send_random_chunk();
    int pick;
    int n;
    logic [7:0] b;
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      n = $urandom_range(0, 10);
      for (int k = 0; k < n; k++) begin
        case ($urandom_range(0, 9))
          0: send_beat(glc_pkg::CH_SPACE, 1'b0);
          1: begin
            send_beat(glc_pkg::CH_LPAREN, 1'b0);
            repeat ($urandom_range(0, 5)) send_beat(8'($urandom_range(33, 126)), 1'b0);
            send_beat(glc_pkg::CH_RPAREN, 1'b0);
          end
          2: send_beat(glc_pkg::CH_SLASH, 1'b0);
          3: send_beat(8'($urandom_range(128, 255)), 1'b0);
          default: begin
            b = glc_pkg::CH_UA + 8'($urandom_range(0, 25));
            if ($urandom_range(0, 1)) b = b + (glc_pkg::CH_LA - glc_pkg::CH_UA);
            send_beat(b, 1'b0);
            repeat ($urandom_range(1, 4))
              send_beat(number_chars[$urandom_range(0, 11)], 1'b0);
          end
        endcase
      end
      if ($urandom_range(0, 4) == 0) begin
        send_beat(glc_pkg::CH_SEMI, 1'b0);
        repeat ($urandom_range(0, 5)) send_beat(8'($urandom_range(33, 255)), 1'b0);
      end
      case ($urandom_range(0, 2))
        0: send_beat(glc_pkg::CH_LF, 1'b0);
        1: send_beat(glc_pkg::CH_CR, 1'b0);
        default: send_text("\r\n");
      endcase
    end else if (pick < 60) begin
      send_text(query_lines[$urandom_range(0, query_lines.size() - 1)]);
      send_beat($urandom_range(0, 1) ? glc_pkg::CH_LF : glc_pkg::CH_CR, 1'b0);
    end else if (pick < 70) begin
      case ($urandom_range(0, 2))
        0: send_beat(glc_pkg::CH_BANG, 1'b0);
        1: send_beat(glc_pkg::CH_TILDE, 1'b0);
        default: send_beat(glc_pkg::CH_CAN, 1'b0);
      endcase
    end else if (pick < 80) begin
      repeat ($urandom_range(1, 6)) send_beat(8'($urandom_range(0, 255)), 1'b0);
    end else if (pick < 86) begin
      send_beat(8'($urandom_range(0, 255)), 1'b1);
    end else if (pick < 96) begin
      case ($urandom_range(0, 2))
        0: send_beat(glc_pkg::CH_LF, 1'b0);
        1: send_text("  \r\n");
        default: send_text("\t\n");
      endcase
    end else begin
      n = $urandom_range(120, 140);
      repeat (n) send_beat(glc_pkg::CH_UA + 8'($urandom_range(0, 25)), 1'b0);
      send_beat(glc_pkg::CH_LF, 1'b0);
    end
  endtask

  task automatic test_random();
    int target;
    for (int phase = 0; phase < 6; phase++) begin
      write_mode(phase[0]);
      target = sent_items + 200;
      while (sent_items < target) send_random_chunk();
    end
    write_mode(1'b0);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_serial_line();
    test_realtime();
    test_file_mode();
    test_overflow();
    test_line_count();
    test_backpressure();
    test_random();
    drain();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && line_events.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
